### rtl/vibp_pkg.sv
// Package for the varint index bit packer: payload structs, status codes,
// register indexes and the packing width helper. No dependencies.
`timescale 1ns / 1ps

package vibp_pkg;

	// Stream geometry.
	localparam int unsigned GROUP_BITS = 7;
	localparam int unsigned LIMIT_BITS = 35;
	localparam int unsigned WORD_BITS  = 64;
	localparam int unsigned MAX_GROUPS = LIMIT_BITS / GROUP_BITS;

	// Input item codes.
	localparam logic FUNC_DATA = 1'b0;
	localparam logic FUNC_END  = 1'b1;

	// Configuration register indexes.
	localparam logic REG_EXPECTED_ENTRIES = 1'b0;
	localparam logic REG_MAX_INDEX        = 1'b1;

	// Status codes.
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_OVER32   = 3'd1,
		ST_RANGE    = 3'd2,
		ST_TOO_MANY = 3'd3,
		ST_TOO_LONG = 3'd4,
		ST_TRUNC    = 3'd5,
		ST_MISMATCH = 3'd6
	} status_t;

	typedef struct packed {
		logic       func;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [63:0] packed_word;
		logic        word_valid;
		logic [2:0]  status;
		logic        stream_done;
	} result_t;

	// Configuration as seen by the packing core.
	typedef struct packed {
		logic [31:0] expected_entries;
		logic [31:0] max_index;
		logic [5:0]  pack_width;
	} cfg_t;

	// Bit length of a value, at least 1.
	function automatic logic [5:0] bit_length(input logic [31:0] v);
		logic [5:0] n;
		n = 6'd1;
		for (int i = 1; i < 32; i++) begin
			if (v[i]) begin
				n = 6'(i + 1);
			end
		end
		return n;
	endfunction

endpackage

### rtl/vibp_cfg.sv
// Configuration registers of the varint index bit packer.
// Holds the expected entry count, the largest index and its packing width. Uses vibp_pkg.
`timescale 1ns / 1ps

module vibp_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_index,
	input  logic [31:0]       cfg_data,
	output vibp_pkg::cfg_t    cfg
);
	import vibp_pkg::*;

	logic [31:0] expected_entries_q;
	logic [31:0] max_index_q;
	logic [5:0]  pack_width_q;

	// Register writes; the packing width is derived once at write time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_entries_q <= 32'd1;
			max_index_q        <= 32'd0;
			pack_width_q       <= 6'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_EXPECTED_ENTRIES: begin
					expected_entries_q <= cfg_data;
				end
				REG_MAX_INDEX: begin
					max_index_q  <= cfg_data;
					pack_width_q <= bit_length(cfg_data);
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.expected_entries = expected_entries_q;
	assign cfg.max_index        = max_index_q;
	assign cfg.pack_width       = pack_width_q;

endmodule

### rtl/vibp_core.sv
// Stream state and per-item logic of the varint index bit packer: varint
// accumulation, checks, bit packing and end-of-stream status. Uses vibp_pkg.
`timescale 1ns / 1ps

module vibp_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  vibp_pkg::item_t     item,
	input  vibp_pkg::cfg_t      cfg,
	output vibp_pkg::result_t   result,
	output logic [2:0]          error_code,
	output logic [5:0]          fill_position
);
	import vibp_pkg::*;

	logic [34:0] value_accum_q;
	logic [2:0]  group_count_q;
	logic [31:0] entry_count_q;
	logic [63:0] word_accum_q;
	logic [5:0]  fill_position_q;
	logic [2:0]  error_code_q;

	logic [34:0] value_accum_d;
	logic [2:0]  group_count_d;
	logic [31:0] entry_count_d;
	logic [63:0] word_accum_d;
	logic [5:0]  fill_position_d;
	logic [2:0]  error_code_d;

	logic [4:0]  grp_shift;
	logic [34:0] acc_new;
	logic [2:0]  gc_inc;
	logic [63:0] word_or;
	logic [6:0]  end_pos;

	// Datapath terms shared by the data-byte cases.
	always_comb begin
		grp_shift = {2'b00, group_count_q} * 5'(GROUP_BITS);
		acc_new   = value_accum_q | (35'(item.data_byte[6:0]) << grp_shift);
		gc_inc    = group_count_q + 3'd1;
		word_or   = word_accum_q | (64'(acc_new[31:0]) << fill_position_q);
		end_pos   = 7'(fill_position_q) + 7'(cfg.pack_width);
	end

	// Next state and the result of the current item.
	always_comb begin
		value_accum_d      = value_accum_q;
		group_count_d      = group_count_q;
		entry_count_d      = entry_count_q;
		word_accum_d       = word_accum_q;
		fill_position_d    = fill_position_q;
		error_code_d       = error_code_q;
		result.packed_word = 64'd0;
		result.word_valid  = 1'b0;
		result.stream_done = 1'b0;
		result.status      = ST_OK;

		if (item.func == FUNC_END) begin
			if (error_code_q != ST_OK) begin
				result.status = error_code_q;
			end else if (group_count_q != 3'd0) begin
				result.status = ST_TRUNC;
			end else if (entry_count_q != cfg.expected_entries) begin
				result.status = ST_MISMATCH;
			end
			if (fill_position_q != 6'd0) begin
				result.packed_word = word_accum_q;
				result.word_valid  = 1'b1;
			end
			result.stream_done = 1'b1;
			value_accum_d      = 35'd0;
			group_count_d      = 3'd0;
			entry_count_d      = 32'd0;
			word_accum_d       = 64'd0;
			fill_position_d    = 6'd0;
			error_code_d       = ST_OK;
		end else begin
			if (error_code_q == ST_OK) begin
				if (!item.data_byte[7]) begin
					// Last byte of a varint: check, then pack.
					value_accum_d = 35'd0;
					group_count_d = 3'd0;
					if (acc_new[34:32] != 3'd0) begin
						error_code_d = ST_OVER32;
					end else if (acc_new[31:0] > cfg.max_index) begin
						error_code_d = ST_RANGE;
					end else if (entry_count_q >= cfg.expected_entries) begin
						error_code_d = ST_TOO_MANY;
					end else begin
						entry_count_d = entry_count_q + 32'd1;
						if (end_pos[6]) begin
							result.packed_word = word_or;
							result.word_valid  = 1'b1;
							word_accum_d = (fill_position_q != 6'd0) ?
								(64'(acc_new[31:0]) >> (7'(WORD_BITS) - 7'(fill_position_q))) :
								64'd0;
						end else begin
							word_accum_d = word_or;
						end
						fill_position_d = end_pos[5:0];
					end
				end else begin
					// Continuation byte: a fifth one makes the varint too long.
					if (gc_inc == 3'(MAX_GROUPS)) begin
						error_code_d  = ST_TOO_LONG;
						group_count_d = 3'd0;
						value_accum_d = 35'd0;
					end else begin
						group_count_d = gc_inc;
						value_accum_d = acc_new;
					end
				end
			end
			result.status = error_code_d;
		end
	end

	// Stream state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_accum_q   <= 35'd0;
			group_count_q   <= 3'd0;
			entry_count_q   <= 32'd0;
			word_accum_q    <= 64'd0;
			fill_position_q <= 6'd0;
			error_code_q    <= ST_OK;
		end else if (advance) begin
			value_accum_q   <= value_accum_d;
			group_count_q   <= group_count_d;
			entry_count_q   <= entry_count_d;
			word_accum_q    <= word_accum_d;
			fill_position_q <= fill_position_d;
			error_code_q    <= error_code_d;
		end
	end

	assign error_code    = error_code_q;
	assign fill_position = fill_position_q;

endmodule

### rtl/varint_index_bit_packer.sv
// Top level of the varint index bit packer: input register, result register
// and handshakes. Instantiates vibp_cfg and vibp_core; uses vibp_pkg.
//
// Usage:
//  - item channel (item_valid / item_stall / item) carries one stream byte or
//    an end-of-stream marker per transfer. Each item gives exactly one result.
//  - result channel (result_valid / result_stall / result) returns the packed
//    word, if one filled, the current status and the end-of-stream flag.
//  - cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the
//    expected entry count (index 0) and the largest index (index 1). It is
//    always ready; write it only while no item is in flight.
//  - Path: a transferred item is registered in the input stage, then
//    processed by the packing core into the result register and shown on
//    the result port.
//  - Throughput: one item per cycle while the result is not stalled,
//    bounded by the single state update of the packing core per cycle.
//  - Reset clears both stages, the stream state and the registers
//    (expected entries 1, largest index 0).
//  - A stalled result holds; the input stage then fills and item_stall rises
//    until the result is taken. Nothing is dropped.
`timescale 1ns / 1ps

module varint_index_bit_packer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  vibp_pkg::item_t     item,
	output logic                result_valid,
	input  logic                result_stall,
	output vibp_pkg::result_t   result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [31:0]         cfg_data
);
	import vibp_pkg::*;

	item_t       item_s1;
	logic        valid_s1;
	result_t     result_s2;
	logic        valid_s2;
	logic        advance;
	cfg_t        cfg;
	result_t     core_result;
	logic [2:0]  error_code;
	logic [5:0]  fill_position;

	assign cfg_ready = 1'b1;

	vibp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	vibp_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.item          (item_s1),
		.cfg           (cfg),
		.result        (core_result),
		.error_code    (error_code),
		.fill_position (fill_position)
	);

	// The held item moves on when the result register is empty or draining.
	assign advance    = valid_s1 & (~valid_s2 | ~result_stall);
	assign item_stall = valid_s1 & ~advance;

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid & ~item_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid & ~item_stall) begin
			item_s1 <= item;
		end
	end

	// Result stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (~result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= core_result;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

`ifndef SYNTHESIS
	// End of stream leaves the stream state clean.
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.func == FUNC_END |=> error_code == ST_OK && fill_position == 6'd0)
		else $error("end of stream did not clear the stream state");

	// Once an error is sticky, data bytes do not pack.
	a_sticky_no_pack: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.func == FUNC_DATA && error_code != ST_OK
		|=> $stable(fill_position) && error_code == $past(error_code))
		else $error("data byte changed state under a sticky error");

	// A word from a data byte comes only while no error is held.
	a_word_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.word_valid && !result.stream_done |-> result.status == ST_OK)
		else $error("word emitted with an error status");

	// The input stage only stalls while it holds an item.
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && valid_s2 && result_stall)
		else $error("input stalled without a blocked item");
`endif

endmodule
